// ===== src/pss_pkg.sv =====
// Shared types and constants for the priority server selector.
// Holds command, policy and status codes and the controller-to-datapath structs.
// No dependencies.
package pss_pkg;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_SELECT = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_ONLINE = 2'd2,
    CMD_RETIRE = 2'd3
  } cmd_e;

  // Selection policy codes.
  typedef enum logic [1:0] {
    POL_PRICE   = 2'd0,
    POL_QUEUE   = 2'd1,
    POL_PERF    = 2'd2,
    POL_UNKNOWN = 2'd3
  } policy_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_NONE_AVAILABLE = 2'd1,
    ST_NONE_ONLINE    = 2'd2
  } status_e;

  // Configuration register file.
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CAPACITY_RESET = 5'd16;
  localparam logic REG_QUEUE_CAPACITY = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic scan_active;
    logic update;
    logic pick;
    logic out_load;
  } pss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_select;
    logic scan_last;
  } pss_sts_t;

endpackage

// ===== src/pss_datapath.sv =====
// Datapath of the priority server selector: server table, scan compare stage,
// result and output registers.
// Depends on pss_pkg.
module pss_datapath import pss_pkg::*; #(
  parameter int unsigned NUM_SERVERS = 8,
  parameter int unsigned MAX_QUEUE   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pss_cmd_t         ctrl_i,
  output pss_sts_t         sts_o,
  input  logic [CFG_W-1:0] capacity_i,
  input  logic [1:0]       cmd_i,
  input  logic [1:0]       policy_i,
  input  logic [2:0]       server_index_i,
  input  logic [15:0]      price_i,
  input  logic [15:0]      performance_i,
  input  logic             online_flag_i,
  output logic [1:0]       status_o,
  output logic [2:0]       chosen_server_o
);

  localparam int unsigned IDX_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int unsigned QW = $clog2(MAX_QUEUE + 1);
  localparam int unsigned CAPW = (QW > CFG_W) ? QW : CFG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SERVERS - 1);
  localparam logic [CAPW-1:0] MAX_CAP = CAPW'(MAX_QUEUE);

  // Latched item.
  cmd_e             cmd_q;
  policy_e          policy_q;
  logic [15:0]      price_q;
  logic [15:0]      perf_q;
  logic             flag_q;
  logic             idx_ok_q;
  logic [IDX_W-1:0] addr_q;

  // Server table.
  logic [15:0]            price_mem [NUM_SERVERS];
  logic [15:0]            perf_mem  [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] online_q;
  logic [QW-1:0]          queue_q   [NUM_SERVERS];

  // Registered read of the entry at addr_q.
  logic [15:0]      rd_price_q;
  logic [15:0]      rd_perf_q;
  logic             rd_online_q;
  logic [QW-1:0]    rd_queue_q;
  logic [IDX_W-1:0] st_idx_q;
  logic             st_vld_q;

  // Best candidate so far.
  logic             found_q;
  logic             any_online_q;
  logic [15:0]      best_val_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [QW-1:0]    best_queue_q;

  // Result and output payload.
  status_e          res_status_q;
  logic [2:0]       res_chosen_q;
  status_e          out_status_q;
  logic [2:0]       out_chosen_q;

  logic             tbl_we;
  logic             grant;
  logic             q_we;
  logic [IDX_W-1:0] q_waddr;
  logic [QW-1:0]    q_wdata;
  logic [CAPW-1:0]  cap;
  logic             eligible;
  logic [15:0]      cand;
  logic             better;

  assign sts_o.in_select = (cmd_e'(cmd_i) == CMD_SELECT);
  assign sts_o.scan_last = (addr_q == LAST_IDX);

  // Capture the item and step the table address during a scan.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q    <= cmd_e'(cmd_i);
      policy_q <= policy_e'(policy_i);
      price_q  <= price_i;
      perf_q   <= performance_i;
      flag_q   <= online_flag_i;
      idx_ok_q <= (32'(server_index_i) < 32'(NUM_SERVERS));
      addr_q   <= (cmd_e'(cmd_i) == CMD_SELECT) ? '0 : IDX_W'(server_index_i);
    end else if (ctrl_i.scan_step) begin
      addr_q <= addr_q + 1'b1;
    end
  end

  assign tbl_we = ctrl_i.update && idx_ok_q;
  assign grant  = ctrl_i.pick && any_online_q && found_q && (policy_q != POL_UNKNOWN);

  // Price and performance memories: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (tbl_we && (cmd_q == CMD_LOAD)) begin
      price_mem[addr_q] <= price_q;
      perf_mem[addr_q]  <= perf_q;
    end
    rd_price_q <= price_mem[addr_q];
    rd_perf_q  <= perf_mem[addr_q];
  end

  // Queue count write: the granted server goes up, or the addressed one is
  // drained or retires a job.
  always_comb begin
    q_we    = 1'b0;
    q_waddr = addr_q;
    q_wdata = rd_queue_q;
    if (grant) begin
      q_we    = 1'b1;
      q_waddr = best_idx_q;
      q_wdata = best_queue_q + 1'b1;
    end else if (tbl_we) begin
      case (cmd_q)
        CMD_ONLINE: begin
          if (!flag_q) begin
            q_we    = 1'b1;
            q_wdata = '0;
          end
        end
        CMD_RETIRE: begin
          if (rd_queue_q != '0) begin
            q_we    = 1'b1;
            q_wdata = rd_queue_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Online flags and queue counts clear on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= '0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        queue_q[i] <= '0;
      end
    end else begin
      if (tbl_we && (cmd_q == CMD_ONLINE)) begin
        online_q[addr_q] <= flag_q;
      end
      if (q_we) begin
        queue_q[q_waddr] <= q_wdata;
      end
    end
  end

  // Read stage for the flag and count, aligned with the memory read.
  always_ff @(posedge clk_i) begin
    rd_online_q <= online_q[addr_q];
    rd_queue_q  <= queue_q[addr_q];
    st_idx_q    <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= ctrl_i.scan_active;
    end
  end

  // Compare the entry in the read stage against the best so far.
  always_comb begin
    cap      = (CAPW'(capacity_i) > MAX_CAP) ? MAX_CAP : CAPW'(capacity_i);
    eligible = rd_online_q && (CAPW'(rd_queue_q) < cap);
    case (policy_q)
      POL_PRICE: cand = rd_price_q;
      POL_QUEUE: cand = 16'(rd_queue_q);
      default:   cand = rd_perf_q;
    endcase
    better = !found_q ||
             ((policy_q == POL_PERF) ? (cand > best_val_q) : (cand < best_val_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      any_online_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      found_q      <= 1'b0;
      any_online_q <= 1'b0;
    end else if (st_vld_q) begin
      any_online_q <= any_online_q | rd_online_q;
      if (eligible && better) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_vld_q && eligible && better) begin
      best_val_q   <= cand;
      best_idx_q   <= st_idx_q;
      best_queue_q <= rd_queue_q;
    end
  end

  // Form the result, then move it to the output register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.update) begin
      res_status_q <= ST_OK;
      res_chosen_q <= '0;
    end else if (ctrl_i.pick) begin
      if (!any_online_q) begin
        res_status_q <= ST_NONE_ONLINE;
        res_chosen_q <= '0;
      end else if (!grant) begin
        res_status_q <= ST_NONE_AVAILABLE;
        res_chosen_q <= '0;
      end else begin
        res_status_q <= ST_OK;
        res_chosen_q <= 3'(best_idx_q);
      end
    end
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_chosen_q <= res_chosen_q;
    end
  end

  assign status_o        = out_status_q;
  assign chosen_server_o = out_chosen_q;

endmodule

// ===== src/pss_ctrl.sv =====
// Controller of the priority server selector: sequences capture, table scan,
// update and output handoff.
// Depends on pss_pkg.
module pss_ctrl import pss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  pss_sts_t sts_i,
  output pss_cmd_t ctrl_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FETCH  = 7'b0000010,
    S_UPDATE = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_PICK   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = sts_i.in_select ? S_SCAN : S_FETCH;
        end
      end
      S_FETCH:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_DONE;
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_PICK;
      S_PICK:   state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctrl_o.capture     = in_acc;
    ctrl_o.scan_step   = (state_q == S_SCAN) && !sts_i.scan_last;
    ctrl_o.scan_active = (state_q == S_SCAN);
    ctrl_o.update      = (state_q == S_UPDATE);
    ctrl_o.pick        = (state_q == S_PICK);
    ctrl_o.out_load    = (state_q == S_DONE) && out_free;
  end

  // Output valid holds until the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== src/priority_server_selector.sv =====
// Priority server selector: a selection request scans the table, reading one server
// entry per cycle through the table port, then picks a result; load, online and retire
// commands fetch and update the addressed entry. The block takes no new command until
// the result of the current one has moved to the output register.
// Reset (rst_ni low, asynchronous) takes every server offline, empties all queues
// and sets the queue capacity to 16; prices and performances stay unknown until loaded.
module priority_server_selector import pss_pkg::*; #(
  parameter int unsigned NUM_SERVERS = 8,
  parameter int unsigned MAX_QUEUE   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  policy_i,
  input  logic [2:0]  server_index_i,
  input  logic [15:0] price_i,
  input  logic [15:0] performance_i,
  input  logic        online_flag_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  chosen_server_o
);

  logic [CFG_W-1:0] queue_capacity_q;
  pss_cmd_t         ctrl;
  pss_sts_t         sts;

  // Configuration register; written in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_capacity_q <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_QUEUE_CAPACITY)) begin
      queue_capacity_q <= pwdata[CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUEUE_CAPACITY) ? 32'(queue_capacity_q) : '0;

  pss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctrl_o      (ctrl)
  );

  pss_datapath #(
    .NUM_SERVERS (NUM_SERVERS),
    .MAX_QUEUE   (MAX_QUEUE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .sts_o           (sts),
    .capacity_i      (queue_capacity_q),
    .cmd_i           (cmd_i),
    .policy_i        (policy_i),
    .server_index_i  (server_index_i),
    .price_i         (price_i),
    .performance_i   (performance_i),
    .online_flag_i   (online_flag_i),
    .status_o        (status_o),
    .chosen_server_o (chosen_server_o)
  );

endmodule

// ===== src/pss_checker.sv =====
// Port-level checks for the priority server selector, bound to the top level.
// Depends on pss_pkg and priority_server_selector.
module pss_checker import pss_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [2:0] chosen_server_o
);

  // A stalled result item holds its valid and payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(chosen_server_o))
    else $error("stalled result item changed");

  // The block works on one item at a time, so it stalls right after accepting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while busy");

  // A failed selection reports server zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (chosen_server_o == 3'd0))
    else $error("nonzero server with failure status");

  // No result is offered as reset is released.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind priority_server_selector pss_checker u_pss_checker (.*);
